// ----- hw/rtl/multi_sensor_threshold_alarm_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the threshold alarm
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_SENSOR_THRESHOLD_ALARM_MACROS_SVH
`define MULTI_SENSOR_THRESHOLD_ALARM_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define MSTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msta assertion failed");
// Next-cycle implication.
`define MSTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msta assertion failed");
`else
`define MSTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MSTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/msta_pkg.sv -----
// ----------------------------------------------------------------------------
// msta_pkg
// Widths, register indexes, channel masks and types of the threshold alarm.
// ----------------------------------------------------------------------------
package msta_pkg;

  localparam int unsigned GAS_ADC_BITS = 12;
  localparam int unsigned TIME_BITS    = 32;
  localparam int unsigned NUM_CH       = 10;

  localparam int unsigned GAS_W   = 4 * GAS_ADC_BITS;
  localparam int unsigned CFG_W   = (GAS_W > 32) ? GAS_W : 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Input tdata layout, lowest field first.
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned HUM_W    = 14;
  localparam int unsigned PART_W   = 16;
  localparam int unsigned IN_BITS  = TEMP_W + HUM_W + GAS_W + 2 * PART_W + 1;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OFS_HUM    = TEMP_W;
  localparam int unsigned OFS_GAS    = OFS_HUM + HUM_W;
  localparam int unsigned OFS_FINE   = OFS_GAS + GAS_W;
  localparam int unsigned OFS_COARSE = OFS_FINE + PART_W;
  localparam int unsigned OFS_PVALID = OFS_COARSE + PART_W;

  // Output tdata layout, lowest field first.
  localparam int unsigned OUT_BITS = 4 + 2 + 1 + NUM_CH;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMIDITY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BUZZER     = 3'd7;

  // Register reset values.
  localparam logic [15:0]        RST_TEMP_HIGH = 16'd3500;
  localparam logic [15:0]        RST_TEMP_LOW  = 16'd500;
  localparam logic [31:0]        RST_HUMIDITY  = {16'd8000, 16'd2000};
  localparam logic [GAS_W-1:0]   RST_GAS       = {4{GAS_ADC_BITS'(2000)}};
  localparam logic [31:0]        RST_PARTICLE  = {16'd50, 16'd35};
  localparam logic [31:0]        RST_COOLDOWN  = 32'd60000;
  localparam logic [31:0]        RST_BLINK     = 32'd500;
  localparam logic [31:0]        RST_BUZZER    = 32'd3000;

  // Temperature high/low, combustible gas, methane and carbon monoxide are critical channels.
  localparam logic [NUM_CH-1:0] CRIT_MASK = 10'b00_1110_0011;

  localparam int unsigned CH_FINE   = 8;
  localparam int unsigned CH_COARSE = 9;

  typedef enum logic [1:0] {
    LVL_NORMAL   = 2'd0,
    LVL_WARNING  = 2'd1,
    LVL_CRITICAL = 2'd2
  } level_e;

  // Lamp drives: bit 0 green, bit 1 yellow, bit 2 red.
  localparam logic [2:0] LAMP_OFF    = 3'b000;
  localparam logic [2:0] LAMP_GREEN  = 3'b001;
  localparam logic [2:0] LAMP_YELLOW = 3'b010;
  localparam logic [2:0] LAMP_RED    = 3'b100;

endpackage

// ----- hw/rtl/multi_sensor_threshold_alarm.sv -----
// ----------------------------------------------------------------------------
// multi_sensor_threshold_alarm: ten-channel threshold alarm with lamps and buzzer.
// An accepted item waits in the input register; its result is held in the result register and offered from there.
// One item per cycle unless the output stalls; ten channel compares and cooldown checks run side by side.
// Reset (rst_ni, asynchronous, active low): default limits, time and channels cleared, green lamp on.
// ----------------------------------------------------------------------------
`include "multi_sensor_threshold_alarm_macros.svh"

module multi_sensor_threshold_alarm (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [msta_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [msta_pkg::CFG_W-1:0]        cfg_data_i,
  // Item input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0: temperature, humidity, air_quality, combustible_gas,
  // methane, carbon_monoxide, fine_particles, coarse_particles,
  // particles_valid, zero fill
  input  logic [msta_pkg::IN_W-1:0]         s_axis_tdata,
  // tuser: mode (0 tick, 1 sample)
  input  logic                              s_axis_tuser,
  // Result output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata from bit 0: green_lamp, yellow_lamp, red_lamp, buzzer_on,
  // alert_level, alert_fired, active_channels, zero fill
  output logic [msta_pkg::OUT_W-1:0]        m_axis_tdata
);

  localparam int unsigned G  = msta_pkg::GAS_ADC_BITS;
  localparam int unsigned TB = msta_pkg::TIME_BITS;
  localparam int unsigned NC = msta_pkg::NUM_CH;

  // Configuration registers
  logic signed [15:0]         temp_high_q, temp_low_q;
  logic [31:0]                hum_lim_q;
  logic [msta_pkg::GAS_W-1:0] gas_lim_q;
  logic [31:0]                part_lim_q;
  logic [31:0]                cooldown_q, blink_ivl_q, buz_dur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_high_q <= msta_pkg::RST_TEMP_HIGH;
      temp_low_q  <= msta_pkg::RST_TEMP_LOW;
      hum_lim_q   <= msta_pkg::RST_HUMIDITY;
      gas_lim_q   <= msta_pkg::RST_GAS;
      part_lim_q  <= msta_pkg::RST_PARTICLE;
      cooldown_q  <= msta_pkg::RST_COOLDOWN;
      blink_ivl_q <= msta_pkg::RST_BLINK;
      buz_dur_q   <= msta_pkg::RST_BUZZER;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        msta_pkg::CFG_TEMP_HIGH: temp_high_q <= cfg_data_i[15:0];
        msta_pkg::CFG_TEMP_LOW:  temp_low_q  <= cfg_data_i[15:0];
        msta_pkg::CFG_HUMIDITY:  hum_lim_q   <= cfg_data_i[31:0];
        msta_pkg::CFG_GAS:       gas_lim_q   <= cfg_data_i[msta_pkg::GAS_W-1:0];
        msta_pkg::CFG_PARTICLE:  part_lim_q  <= cfg_data_i[31:0];
        msta_pkg::CFG_COOLDOWN:  cooldown_q  <= cfg_data_i[31:0];
        msta_pkg::CFG_BLINK:     blink_ivl_q <= cfg_data_i[31:0];
        msta_pkg::CFG_BUZZER:    buz_dur_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                              in_vld_q;
  logic                              in_mode_q;
  logic [msta_pkg::IN_W-1:0]         in_data_q;
  logic                              out_vld_q;
  logic [msta_pkg::OUT_BITS-1:0]     out_data_q;
  logic                              advance;

  assign advance       = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q <= s_axis_tuser;
      in_data_q <= s_axis_tdata;
    end
  end

  // Field views of the registered item
  logic signed [15:0]          temp;
  logic [msta_pkg::HUM_W-1:0]  hum;
  logic [msta_pkg::GAS_W-1:0]  gas;
  logic [15:0]                 fine, coarse;
  logic                        pvalid;

  assign temp   = in_data_q[msta_pkg::TEMP_W-1:0];
  assign hum    = in_data_q[msta_pkg::OFS_HUM +: msta_pkg::HUM_W];
  assign gas    = in_data_q[msta_pkg::OFS_GAS +: msta_pkg::GAS_W];
  assign fine   = in_data_q[msta_pkg::OFS_FINE +: msta_pkg::PART_W];
  assign coarse = in_data_q[msta_pkg::OFS_COARSE +: msta_pkg::PART_W];
  assign pvalid = in_data_q[msta_pkg::OFS_PVALID];

  // Alarm state
  logic [TB-1:0]         now_q, now_d;
  logic [TB-1:0]         stamps_q [NC];
  logic [TB-1:0]         stamps_d [NC];
  logic [NC-1:0]         active_q, active_d;
  msta_pkg::level_e      level_q, level_d;
  logic                  blink_q, blink_d;
  logic [TB-1:0]         last_blink_q, last_blink_d;
  logic                  buz_run_q, buz_run_d;
  logic [TB-1:0]         buz_start_q, buz_start_d;
  logic [2:0]            lamps_q, lamps_d;
  logic                  buz_out_q, buz_out_d;

  logic [NC-1:0]         over, enable, fire;
  logic [TB-1:0]         now_inc, blink_diff, buz_diff;
  logic [TB-1:0]         ch_diff [NC];
  logic                  any_fire;

  always_comb begin
    over[0] = temp > temp_high_q;
    over[1] = temp < temp_low_q;
    over[2] = 16'(hum) > hum_lim_q[31:16];
    over[3] = 16'(hum) < hum_lim_q[15:0];
    for (int k = 0; k < 4; k++) begin
      over[4+k] = gas[k*G +: G] > gas_lim_q[k*G +: G];
    end
    over[msta_pkg::CH_FINE]   = fine > part_lim_q[15:0];
    over[msta_pkg::CH_COARSE] = coarse > part_lim_q[31:16];

    // Particle channels hold their state while the readings are invalid.
    enable = '1;
    enable[msta_pkg::CH_FINE]   = pvalid;
    enable[msta_pkg::CH_COARSE] = pvalid;

    for (int c = 0; c < NC; c++) begin
      ch_diff[c] = now_q - stamps_q[c];
      fire[c]    = enable[c] & over[c] & (~active_q[c] | (32'(ch_diff[c]) > cooldown_q));
    end
    any_fire = |fire;

    now_inc    = now_q + TB'(1);
    blink_diff = now_inc - last_blink_q;
    buz_diff   = now_inc - buz_start_q;

    now_d        = now_q;
    stamps_d     = stamps_q;
    active_d     = active_q;
    level_d      = level_q;
    blink_d      = blink_q;
    last_blink_d = last_blink_q;
    buz_run_d    = buz_run_q;
    buz_start_d  = buz_start_q;
    lamps_d      = lamps_q;
    buz_out_d    = buz_out_q;

    if (in_mode_q) begin
      for (int c = 0; c < NC; c++) begin
        // An over-limit channel that cannot refire is already active.
        if (enable[c]) begin
          active_d[c] = over[c];
        end
        if (fire[c]) begin
          stamps_d[c] = now_q;
        end
      end
      if (any_fire) begin
        level_d = |(fire & msta_pkg::CRIT_MASK) ? msta_pkg::LVL_CRITICAL
                                                : msta_pkg::LVL_WARNING;
        if (|(fire & msta_pkg::CRIT_MASK) && !buz_run_q) begin
          buz_run_d   = 1'b1;
          buz_start_d = now_q;
          buz_out_d   = 1'b1;
        end
      end else if (active_d == '0) begin
        level_d = msta_pkg::LVL_NORMAL;
      end
    end else begin
      now_d = now_inc;
      if (32'(blink_diff) >= blink_ivl_q) begin
        last_blink_d = now_inc;
        blink_d      = ~blink_q;
        unique case (level_q)
          msta_pkg::LVL_WARNING:  lamps_d = blink_d ? msta_pkg::LAMP_YELLOW : msta_pkg::LAMP_OFF;
          msta_pkg::LVL_CRITICAL: lamps_d = blink_d ? msta_pkg::LAMP_RED : msta_pkg::LAMP_OFF;
          default:                lamps_d = msta_pkg::LAMP_GREEN;
        endcase
      end
      if (buz_run_q) begin
        if (32'(buz_diff) >= buz_dur_q) begin
          buz_out_d = 1'b0;
          buz_run_d = 1'b0;
        end else begin
          buz_out_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      stamps_q     <= '{default: '0};
      active_q     <= '0;
      level_q      <= msta_pkg::LVL_NORMAL;
      blink_q      <= 1'b0;
      last_blink_q <= '0;
      buz_run_q    <= 1'b0;
      buz_start_q  <= '0;
      lamps_q      <= msta_pkg::LAMP_GREEN;
      buz_out_q    <= 1'b0;
    end else if (advance) begin
      now_q        <= now_d;
      stamps_q     <= stamps_d;
      active_q     <= active_d;
      level_q      <= level_d;
      blink_q      <= blink_d;
      last_blink_q <= last_blink_d;
      buz_run_q    <= buz_run_d;
      buz_start_q  <= buz_start_d;
      lamps_q      <= lamps_d;
      buz_out_q    <= buz_out_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {active_d, in_mode_q & any_fire, level_d, buz_out_d, lamps_d};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = msta_pkg::OUT_W'(out_data_q);

  `MSTA_ASSERT_IMP(a_buzzer_drive, clk_i, rst_ni, buz_run_q, buz_out_q)
  `MSTA_ASSERT_IMP(a_normal_idle, clk_i, rst_ni, level_q == msta_pkg::LVL_NORMAL, active_q == '0)
  `MSTA_ASSERT_IMP(a_one_lamp, clk_i, rst_ni, 1'b1, $onehot0(lamps_q))
  `MSTA_ASSERT_NXT(a_fire_level, clk_i, rst_ni, advance && in_mode_q && any_fire, level_q != msta_pkg::LVL_NORMAL)

endmodule
